// ----- rtl/core/gbt_pkg.sv -----
// shared types and constants for the graph traversal block
package gbt_pkg;

    localparam int DEF_MAX_VERTICES     = 64;
    localparam int DEF_MAX_EDGE_ENTRIES = 256;
    localparam int VERT_W               = 6;
    localparam int CFG_W                = 7;
    localparam int STAT_W               = 2;
    localparam int MAX_RESULTS          = 64;
    localparam int RES_W                = 7;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_BFS   = 2'd1,
        FUNC_DFS   = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RA,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_EMIT,
        ST_HEAD,
        ST_BFS_EDGE,
        ST_BFS_EDAT,
        ST_BFS_NEXT,
        ST_BFS_QDAT,
        ST_DFS_STEP,
        ST_DFS_POP,
        ST_DFS_EDAT,
        ST_FINISH
    } state_t;

    // request from the sequencer to the result stage
    typedef struct packed {
        logic              push;
        logic              finish;
        logic [VERT_W-1:0] vertex;
        status_t           status;
    } out_req_t;

endpackage

// ----- rtl/core/gbt_ram.sv -----
// generic single write port ram with registered read
module gbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/gbt_out.sv -----
// result stage: one held-back result so the final one can be marked last
module gbt_out
    import gbt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  out_req_t          req,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VERT_W-1:0] m_vertex,
    output logic              m_last,
    output logic [STAT_W-1:0] m_status
);

    logic              pend_valid_reg;
    logic [VERT_W-1:0] pend_vertex_reg;
    status_t           pend_status_reg;
    logic              out_valid_reg;
    logic [VERT_W-1:0] out_vertex_reg;
    logic              out_last_reg;
    status_t           out_status_reg;
    logic              load;

    assign out_free = !out_valid_reg || m_ready;
    assign load     = (req.push && pend_valid_reg) || req.finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (req.push) begin
                pend_valid_reg <= 1'b1;
            end else if (req.finish) begin
                pend_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            out_vertex_reg <= pend_vertex_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= req.finish;
        end
        if (req.push) begin
            pend_vertex_reg <= req.vertex;
            pend_status_reg <= req.status;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_vertex = out_vertex_reg;
    assign m_last   = out_last_reg;
    assign m_status = out_status_reg;

endmodule

// ----- rtl/core/gbt_seq.sv -----
// sequencer with neighbor-list, queue and stack memories
module gbt_seq
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES     = DEF_MAX_VERTICES,
    parameter int MAX_EDGE_ENTRIES = DEF_MAX_EDGE_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [VERT_W-1:0] s_va,
    input  logic [VERT_W-1:0] s_vb,
    input  logic [CFG_W-1:0]  vertex_count,
    input  logic              out_free,
    output out_req_t          out_req
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int EW    = $clog2(MAX_EDGE_ENTRIES);
    localparam int LW    = $clog2(MAX_EDGE_ENTRIES + 1);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int LIM_W = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_EDGE_ENTRIES);

    state_t              state_reg, state_next;
    logic                dfs_reg, dfs_next;
    logic [VERT_W-1:0]   a_reg, a_next;
    logic [VERT_W-1:0]   b_reg, b_next;
    logic [VERT_W-1:0]   cur_v_reg, cur_v_next;
    logic [LW-1:0]       cur_c_reg, cur_c_next;
    logic [LW-1:0]       eu_reg, eu_next;
    logic [CW-1:0]       rd_reg, rd_next;
    logic [CW-1:0]       wr_reg, wr_next;
    logic [CW-1:0]       top_reg, top_next;
    logic [RES_W-1:0]    n_reg, n_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] hvalid_reg, hvalid_next;

    logic              head_we;
    logic [VW-1:0]     head_waddr, head_raddr;
    logic [LW-1:0]     head_wdata, head_rdata;
    logic              edge_we;
    logic [EW-1:0]     edge_waddr, edge_raddr;
    logic [VERT_W-1:0] nbr_wdata, nbr_rdata;
    logic [LW-1:0]     next_wdata, next_rdata;
    logic              q_we;
    logic [VW-1:0]     q_waddr, q_raddr;
    logic [VERT_W-1:0] q_wdata, q_rdata;
    logic              stk_we;
    logic [VW-1:0]     stk_waddr, stk_raddr;
    logic [LW-1:0]     stk_wdata, stk_rdata;

    logic [LIM_W-1:0]  lim;
    logic              a_ok, b_ok, w_ok, pool_full, c_null;
    logic [VW-1:0]     hv_idx, w_idx;
    logic [LW-1:0]     head_val;

    gbt_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    gbt_ram #(.WIDTH(VERT_W), .DEPTH(MAX_EDGE_ENTRIES)) u_nbr (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(nbr_wdata),
        .raddr(edge_raddr), .rdata(nbr_rdata)
    );
    gbt_ram #(.WIDTH(LW), .DEPTH(MAX_EDGE_ENTRIES)) u_next (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(next_wdata),
        .raddr(edge_raddr), .rdata(next_rdata)
    );
    gbt_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    gbt_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // active vertex limit and range checks
    assign lim = (LIM_W'(vertex_count) > LIM_W'(MAX_VERTICES)) ?
                 LIM_W'(MAX_VERTICES) : LIM_W'(vertex_count);
    assign a_ok = LIM_W'(s_va) < lim;
    assign b_ok = LIM_W'(s_vb) < lim;
    assign w_idx = VW'(nbr_rdata);
    assign w_ok = (LIM_W'(nbr_rdata) < lim) && !visited_reg[w_idx];
    assign pool_full = ((LW + 1)'(eu_reg) + (LW + 1)'(2)) > (LW + 1)'(MAX_EDGE_ENTRIES);
    assign c_null = cur_c_reg >= LINK_NONE;

    always_comb begin
        case (state_reg)
            ST_ADD_WA: hv_idx = VW'(a_reg);
            ST_ADD_WB: hv_idx = VW'(b_reg);
            default:   hv_idx = VW'(cur_v_reg);
        endcase
    end
    assign head_val = hvalid_reg[hv_idx] ? head_rdata : LINK_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            eu_reg      <= '0;
            hvalid_reg  <= '0;
            visited_reg <= '0;
        end else begin
            state_reg   <= state_next;
            eu_reg      <= eu_next;
            hvalid_reg  <= hvalid_next;
            visited_reg <= visited_next;
        end
        dfs_reg   <= dfs_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        cur_v_reg <= cur_v_next;
        cur_c_reg <= cur_c_next;
        rd_reg    <= rd_next;
        wr_reg    <= wr_next;
        top_reg   <= top_next;
        n_reg     <= n_next;
    end

    always_comb begin
        state_next   = state_reg;
        dfs_next     = dfs_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cur_v_next   = cur_v_reg;
        cur_c_next   = cur_c_reg;
        eu_next      = eu_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        top_next     = top_reg;
        n_next       = n_reg;
        visited_next = visited_reg;
        hvalid_next  = hvalid_reg;

        head_we    = 1'b0;
        head_waddr = VW'(a_reg);
        head_wdata = eu_reg;
        head_raddr = VW'(cur_v_reg);
        edge_we    = 1'b0;
        edge_waddr = EW'(eu_reg);
        edge_raddr = EW'(cur_c_reg);
        nbr_wdata  = b_reg;
        next_wdata = head_val;
        q_we       = 1'b0;
        q_waddr    = VW'(wr_reg);
        q_wdata    = nbr_rdata;
        q_raddr    = VW'(rd_reg);
        stk_we     = 1'b0;
        stk_waddr  = VW'(top_reg - CW'(1));
        stk_wdata  = next_rdata;
        stk_raddr  = VW'(top_reg - CW'(2));

        out_req.push   = 1'b0;
        out_req.finish = 1'b0;
        out_req.vertex = cur_v_reg;
        out_req.status = STAT_OK;

        s_ready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next = s_va;
                    b_next = s_vb;
                    case (func_t'(s_func))
                        FUNC_CLEAR: begin
                            hvalid_next  = '0;
                            eu_next      = '0;
                            out_req.push   = 1'b1;
                            out_req.vertex = '0;
                            state_next   = ST_FINISH;
                        end
                        FUNC_ADD: begin
                            if (!(a_ok && b_ok)) begin
                                out_req.push   = 1'b1;
                                out_req.vertex = '0;
                                out_req.status = STAT_RANGE;
                                state_next     = ST_FINISH;
                            end else if (pool_full) begin
                                out_req.push   = 1'b1;
                                out_req.vertex = '0;
                                out_req.status = STAT_FULL;
                                state_next     = ST_FINISH;
                            end else begin
                                state_next = ST_ADD_RA;
                            end
                        end
                        FUNC_BFS, FUNC_DFS: begin
                            if (!a_ok) begin
                                out_req.push   = 1'b1;
                                out_req.vertex = '0;
                                out_req.status = STAT_RANGE;
                                state_next     = ST_FINISH;
                            end else begin
                                visited_next = '0;
                                visited_next[VW'(s_va)] = 1'b1;
                                n_next = '0;
                                if (func_t'(s_func) == FUNC_BFS) begin
                                    dfs_next   = 1'b0;
                                    q_we       = 1'b1;
                                    q_waddr    = '0;
                                    q_wdata    = s_va;
                                    wr_next    = CW'(1);
                                    rd_next    = '0;
                                    state_next = ST_BFS_NEXT;
                                end else begin
                                    dfs_next   = 1'b1;
                                    top_next   = CW'(1);
                                    cur_v_next = s_va;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RA: begin
                head_raddr = VW'(a_reg);
                state_next = ST_ADD_WA;
            end
            ST_ADD_WA: begin
                // link b at the head of a's list
                edge_we    = 1'b1;
                head_we    = 1'b1;
                hvalid_next[VW'(a_reg)] = 1'b1;
                eu_next    = eu_reg + LW'(1);
                state_next = ST_ADD_RB;
            end
            ST_ADD_RB: begin
                head_raddr = VW'(b_reg);
                state_next = ST_ADD_WB;
            end
            ST_ADD_WB: begin
                edge_we    = 1'b1;
                nbr_wdata  = a_reg;
                head_we    = 1'b1;
                head_waddr = VW'(b_reg);
                hvalid_next[VW'(b_reg)] = 1'b1;
                eu_next    = eu_reg + LW'(1);
                out_req.push   = 1'b1;
                out_req.vertex = '0;
                state_next = ST_FINISH;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_req.push = 1'b1;
                    n_next       = n_reg + RES_W'(1);
                    state_next   = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cur_c_next = head_val;
                state_next = dfs_reg ? ST_DFS_STEP : ST_BFS_EDGE;
            end
            ST_BFS_EDGE: begin
                state_next = c_null ? ST_BFS_NEXT : ST_BFS_EDAT;
            end
            ST_BFS_EDAT: begin
                cur_c_next = next_rdata;
                if (w_ok && (wr_reg < CW'(MAX_VERTICES))) begin
                    visited_next[w_idx] = 1'b1;
                    q_we    = 1'b1;
                    wr_next = wr_reg + CW'(1);
                end
                state_next = ST_BFS_EDGE;
            end
            ST_BFS_NEXT: begin
                if ((rd_reg < wr_reg) && (n_reg < RES_W'(MAX_RESULTS))) begin
                    rd_next    = rd_reg + CW'(1);
                    state_next = ST_BFS_QDAT;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_BFS_QDAT: begin
                cur_v_next = q_rdata;
                state_next = ST_EMIT;
            end
            ST_DFS_STEP: begin
                if ((top_reg == '0) || (n_reg >= RES_W'(MAX_RESULTS))) begin
                    state_next = ST_FINISH;
                end else if (c_null) begin
                    // pop; the new top's cursor comes back from the stack memory
                    top_next = top_reg - CW'(1);
                    if (top_reg == CW'(1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_DFS_POP;
                    end
                end else begin
                    state_next = ST_DFS_EDAT;
                end
            end
            ST_DFS_POP: begin
                cur_c_next = stk_rdata;
                state_next = ST_DFS_STEP;
            end
            ST_DFS_EDAT: begin
                cur_c_next = next_rdata;
                if (w_ok && (top_reg < CW'(MAX_VERTICES))) begin
                    visited_next[w_idx] = 1'b1;
                    stk_we     = 1'b1;
                    top_next   = top_reg + CW'(1);
                    cur_v_next = nbr_rdata;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DFS_STEP;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_req.finish = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/graph_bfs_dfs_traversal.sv -----
// top level of the graph traversal block: breadth-first and depth-first walks
//
// The block keeps an undirected graph as per-vertex neighbor lists in an edge
// pool; adding an edge links each endpoint at the head of the other's list,
// so walks see neighbors newest first. One small sequencer does all the work.
// The input stays not ready until the final result is handed to the output
// register. List heads and visited marks live in flip-flop valid bits, so
// reset and clear take effect at once with no sweep. Each walk result is held
// back one step so the final one can carry tlast; rejected and status-only
// results carry vertex 0 and a status code in tuser. vertex_count may be
// rewritten only while the block is idle.
module graph_bfs_dfs_traversal
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES     = DEF_MAX_VERTICES,
    parameter int MAX_EDGE_ENTRIES = DEF_MAX_EDGE_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // func[1:0], vertex_a[7:2], vertex_b[13:8], zeros
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,  // vertex[5:0], zeros
    output logic              m_tlast,
    output logic [STAT_W-1:0] m_tuser,  // status[1:0]
    // vertex_count register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0]  vertex_count_reg;
    out_req_t          out_req;
    logic              out_free;
    logic [VERT_W-1:0] m_vertex;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VCOUNT_RESET;
        end else if (cfg_valid) begin
            vertex_count_reg <= cfg_data;
        end
    end

    // sequencer and graph memories
    gbt_seq #(
        .MAX_VERTICES    (MAX_VERTICES),
        .MAX_EDGE_ENTRIES(MAX_EDGE_ENTRIES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_func      (s_tdata[1:0]),
        .s_va        (s_tdata[7:2]),
        .s_vb        (s_tdata[13:8]),
        .vertex_count(vertex_count_reg),
        .out_free    (out_free),
        .out_req     (out_req)
    );

    // held-back result plus output register
    gbt_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (out_req),
        .out_free(out_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_vertex(m_vertex),
        .m_last  (m_tlast),
        .m_status(m_tuser)
    );

    assign m_tdata = {2'b00, m_vertex};

endmodule

// ----- rtl/core/gbt_checker.sv -----
// port-level checks for the graph traversal block, bound to the top level
module gbt_checker
    import gbt_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [7:0]        m_tdata,
    input logic              m_tlast,
    input logic [STAT_W-1:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // error results end their command
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tlast)
        else $error("error result without last");

    // error results carry vertex zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == 8'd0))
        else $error("error result with nonzero vertex");

    // every accepted command makes the input not ready right after its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (.*);

// ----- tb/tb.sv -----
// testbench for the graph traversal block: scoreboard predictor and stream checks
`timescale 1ns / 100ps

class graph_scoreboard;
    // predicted graph state
    int unsigned vcount;
    int unsigned head[64];
    int unsigned nbr[256];
    int unsigned nxt[256];
    int unsigned used;
    // expected results, oldest first
    logic [5:0] exp_vertex[$];
    logic       exp_last[$];
    logic [1:0] exp_status[$];
    int errors;

    function new();
        vcount = 64;
        errors = 0;
        clear_graph();
    endfunction

    function void clear_graph();
        foreach (head[i]) head[i] = 256;
        used = 0;
    endfunction

    function void push(int unsigned v, bit l, gbt_pkg::status_t s);
        exp_vertex.push_back(v[5:0]);
        exp_last.push_back(l);
        exp_status.push_back(s);
    endfunction

    function int unsigned limit();
        return (vcount > 64) ? 64 : vcount;
    endfunction

    function void walk_bfs(int unsigned start);
        int unsigned q[64];
        bit seen[64];
        int unsigned rd, wr, n, v, c, w;
        rd = 0; wr = 0; n = 0;
        foreach (seen[i]) seen[i] = 0;
        seen[start] = 1;
        q[wr++] = start;
        while (rd < wr && n < 64) begin
            v = q[rd++];
            c = head[v];
            push(v, 0, gbt_pkg::STAT_OK);
            n++;
            while (c < 256) begin
                w = nbr[c];
                if (w < limit() && !seen[w] && wr < 64) begin
                    seen[w] = 1;
                    q[wr++] = w;
                end
                c = nxt[c];
            end
        end
    endfunction

    function void walk_dfs(int unsigned start);
        int unsigned cur[64];
        bit seen[64];
        int unsigned top, n, c, w;
        foreach (seen[i]) seen[i] = 0;
        seen[start] = 1;
        push(start, 0, gbt_pkg::STAT_OK);
        n = 1;
        cur[0] = head[start];
        top = 1;
        while (top > 0 && n < 64) begin
            c = cur[top-1];
            if (c >= 256) begin
                top--;
            end else begin
                w = nbr[c];
                cur[top-1] = nxt[c];
                if (w < limit() && !seen[w] && top < 64) begin
                    seen[w] = 1;
                    push(w, 0, gbt_pkg::STAT_OK);
                    n++;
                    cur[top] = head[w];
                    top++;
                end
            end
        end
    endfunction

    // note an accepted command and predict its results
    function void note_command(gbt_pkg::func_t f, int unsigned a, int unsigned b);
        case (f)
            gbt_pkg::FUNC_CLEAR: begin
                clear_graph();
                push(0, 1, gbt_pkg::STAT_OK);
            end
            gbt_pkg::FUNC_ADD: begin
                if (a >= limit() || b >= limit())
                    push(0, 1, gbt_pkg::STAT_RANGE);
                else if (used + 2 > 256)
                    push(0, 1, gbt_pkg::STAT_FULL);
                else begin
                    nbr[used] = b; nxt[used] = head[a]; head[a] = used; used++;
                    nbr[used] = a; nxt[used] = head[b]; head[b] = used; used++;
                    push(0, 1, gbt_pkg::STAT_OK);
                end
            end
            default: begin
                if (a >= limit())
                    push(0, 1, gbt_pkg::STAT_RANGE);
                else begin
                    if (f == gbt_pkg::FUNC_BFS) walk_bfs(a);
                    else walk_dfs(a);
                    exp_last[$] = 1;
                end
            end
        endcase
    endfunction

    function void check_result(logic [5:0] v, logic l, logic [1:0] s);
        if (exp_vertex.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual vertex %0d last %0b status %0d",
                     $time, v, l, s);
            errors++;
            return;
        end
        if (v !== exp_vertex[0]) begin
            $display("%0t: vertex mismatch: expected %0d, actual %0d", $time, exp_vertex[0], v);
            errors++;
        end
        if (l !== exp_last[0]) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, exp_last[0], l);
            errors++;
        end
        if (s !== exp_status[0]) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp_status[0], s);
            errors++;
        end
        void'(exp_vertex.pop_front());
        void'(exp_last.pop_front());
        void'(exp_status.pop_front());
    endfunction
endclass

module tb;
    import gbt_pkg::*;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic [STAT_W-1:0] m_tuser;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    graph_scoreboard sb = new();
    int stall_mode = 0;
    int unsigned burst_left = 0;

    always #10 aclk = ~aclk;

    graph_bfs_dfs_traversal dut (.*);

    // result side: check every transfer, stall on a rotating pattern
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[5:0], m_tlast, m_tuser);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3, 0) != 0);
                2: m_tready <= ($urandom_range(1, 0) != 0);
                default: m_tready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    // one command transfer, with burst gaps in front
    task automatic send_cmd(func_t f, logic [5:0] a, logic [5:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a, f};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(f, a, b);
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.exp_vertex.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        // rejected or dropped work may still be settling
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_vcount(logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.vcount = v;
    endtask

    // random command mix: mostly edges within range, some walks and noise
    task automatic random_cmd(int unsigned span);
        int unsigned r;
        logic [5:0] a, b;
        r = $urandom_range(99, 0);
        a = (r % 10 == 0) ? 6'($urandom) : 6'($urandom_range(span - 1, 0));
        b = (r % 7 == 0) ? 6'($urandom) : 6'($urandom_range(span - 1, 0));
        if (r < 55)      send_cmd(FUNC_ADD, a, b);
        else if (r < 75) send_cmd(FUNC_BFS, a, b);
        else if (r < 95) send_cmd(FUNC_DFS, a, b);
        else             send_cmd(FUNC_CLEAR, a, b);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: walks on an empty graph, extremes, self loop
        send_cmd(FUNC_BFS, 6'd0, 6'd0);
        send_cmd(FUNC_DFS, 6'd63, 6'd63);
        send_cmd(FUNC_ADD, 6'd0, 6'd63);
        send_cmd(FUNC_ADD, 6'd0, 6'd5);
        send_cmd(FUNC_ADD, 6'd5, 6'd5);
        send_cmd(FUNC_ADD, 6'd5, 6'd42);
        send_cmd(FUNC_ADD, 6'd42, 6'd21);
        send_cmd(FUNC_BFS, 6'd0, 6'd0);
        send_cmd(FUNC_DFS, 6'd0, 6'd0);
        send_cmd(FUNC_DFS, 6'd21, 6'd0);
        send_cmd(FUNC_CLEAR, 6'd63, 6'd63);
        send_cmd(FUNC_BFS, 6'd5, 6'd0);

        // shrink: range errors and neighbors skipped by walks
        send_cmd(FUNC_ADD, 6'd1, 6'd40);
        send_cmd(FUNC_ADD, 6'd1, 6'd2);
        write_vcount(7'd3);
        send_cmd(FUNC_BFS, 6'd1, 6'd0);
        send_cmd(FUNC_DFS, 6'd1, 6'd0);
        send_cmd(FUNC_ADD, 6'd3, 6'd0);
        send_cmd(FUNC_ADD, 6'd0, 6'd3);
        send_cmd(FUNC_BFS, 6'd3, 6'd0);
        write_vcount(7'd0);
        send_cmd(FUNC_DFS, 6'd0, 6'd0);
        send_cmd(FUNC_ADD, 6'd0, 6'd0);
        write_vcount(7'd127);
        send_cmd(FUNC_CLEAR, 6'd0, 6'd0);

        // fill the pool until it overflows, then walk the dense graph
        stall_mode = 1;
        for (int i = 0; i < 130; i++)
            send_cmd(FUNC_ADD, 6'($urandom), 6'($urandom));
        send_cmd(FUNC_BFS, 6'($urandom), 6'd0);
        send_cmd(FUNC_DFS, 6'($urandom), 6'd0);
        write_vcount(7'd64);
        send_cmd(FUNC_CLEAR, 6'd0, 6'd0);

        // random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            stall_mode = ph;
            case (ph)
                0: write_vcount(7'd1);
                1: write_vcount(7'd8);
                2: write_vcount(7'd33);
                default: write_vcount(7'd64);
            endcase
            for (int i = 0; i < 3; i++) begin
                random_cmd((ph == 0) ? 2 : sb.vcount);
                if (i == 1) drain(); // sender holds off until all results are in
            end
        end

        drain();
        if (sb.errors == 0 && sb.exp_vertex.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
